@@ rtl/core/circular_lbp_3x3_stream_assert.svh @@
// Assertion macros used by the checker of the circular LBP stream block.
`ifndef CIRCULAR_LBP_3X3_STREAM_ASSERT_SVH
`define CIRCULAR_LBP_3X3_STREAM_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define CLBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CLBP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/clbp_pkg.sv @@
// Package with shared types, constants and the diagonal compare of the LBP block.
`timescale 1ns / 1ps
`default_nettype none

package clbp_pkg;

    localparam int PIX_W          = 8;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ROW_W          = 12;
    localparam int FW_W           = 12;
    localparam int FH_W           = 13;
    localparam int FW_RESET       = 320;
    localparam int FH_RESET       = 240;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int OUT_DEPTH      = 4;
    localparam int OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

    // Q16 weights of the bilinear diagonal sample
    localparam int W_CORNER = 32768;
    localparam int W_SIDE   = 13573;
    localparam int W_CENTRE = 5622;
    localparam int SUM_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] code;
        logic             last;
    } lbp_result_t;

    // Set when the interpolated diagonal sample lies strictly above the centre.
    function automatic logic diag_bit(
        input logic [PIX_W-1:0] corner,
        input logic [PIX_W-1:0] side_a,
        input logic [PIX_W-1:0] side_b,
        input logic [PIX_W-1:0] centre
    );
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] centre_q16;
        sum = SUM_W'(W_CORNER) * SUM_W'(corner)
            + SUM_W'(W_SIDE) * (SUM_W'(side_a) + SUM_W'(side_b))
            + SUM_W'(W_CENTRE) * SUM_W'(centre);
        centre_q16 = {centre, 16'h0000};
        return sum > centre_q16;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/clbp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module clbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/clbp_out_fifo.sv @@
// Small result FIFO that decouples the fixed-latency pipe from the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module clbp_out_fifo import clbp_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lbp_result_t          push_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lbp_result_t               out_data,
    output logic      [OUT_CNT_W-1:0] count
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    lbp_result_t          mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/circular_lbp_3x3_stream.sv @@
// Circular LBP (8 points, radius 1) over a raster pixel stream. Takes one 8-bit
// pixel per clock while in_ready is high and gives one code per interior pixel,
// for the pixel one row up and one column left of the current one; the first
// two rows and columns give nothing. An input transfer passes the line store
// read, the window shift, and the code compare into the output FIFO. Both line
// stores sit in one RAM word per column that is read and written back on every
// transfer, which sets the rate at one pixel per clock while input is accepted.
// frame_width is clamped to [3, MAX_WIDTH] and frame_height to [3, 4096] on
// write; write them only while the block is idle. After reset no clearing
// pass is needed: the line stores are filled by the first two rows.
`timescale 1ns / 1ps
`default_nettype none

module circular_lbp_3x3_stream import clbp_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  frame_start,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [PIX_W-1:0]      lbp_code,
    output logic                       last
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int LINE_W = 2 * PIX_W;
    localparam int W_RST  = (FW_RESET < MAX_WIDTH) ? FW_RESET : MAX_WIDTH;
    localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(W_RST - 1);
    localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(FH_RESET - 1);

    // Configuration: last column and last row indexes
    logic [COL_W-1:0] w_last_reg;
    logic [COL_W-1:0] w_last_next;
    logic [ROW_W-1:0] h_last_reg;
    logic [ROW_W-1:0] h_last_next;
    logic [CMP_W-1:0] cfg_w;
    logic [FH_W-1:0]  cfg_h;
    logic [COL_W-1:0] w_last_clamp;
    logic [ROW_W-1:0] h_last_clamp;

    // Raster position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             in_fire;

    // Line store read stage
    logic              s1_valid_reg;
    logic              s1_res_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_rd;
    logic [PIX_W-1:0]  top_s1;
    logic [PIX_W-1:0]  mid_s1;

    // Window and code stage
    logic [PIX_W-1:0] win_reg [3][3];
    logic             s2_res_reg;
    logic             s2_last_reg;
    logic [PIX_W-1:0] code;
    lbp_result_t      push_data;
    lbp_result_t      fifo_data;
    logic [OUT_CNT_W-1:0] fifo_count;
    logic [OUT_CNT_W:0]   reserved;

    // Clamp configuration values on write
    assign cfg_ready = 1'b1;
    assign cfg_w     = CMP_W'(cfg_data[FW_W-1:0]);
    assign cfg_h     = cfg_data[FH_W-1:0];

    always_comb
    begin
        priority if (cfg_w < CMP_W'(3))
        begin
            w_last_clamp = COL_W'(2);
        end
        else if (cfg_w > CMP_W'(MAX_WIDTH))
        begin
            w_last_clamp = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last_clamp = COL_W'(cfg_w - CMP_W'(1));
        end

        priority if (cfg_h < FH_W'(3))
        begin
            h_last_clamp = ROW_W'(2);
        end
        else if (cfg_h > FH_W'(HEIGHT_LIMIT))
        begin
            h_last_clamp = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_last_clamp = ROW_W'(cfg_h - FH_W'(1));
        end
    end

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  w_last_next = w_last_clamp;
                REG_FRAME_HEIGHT: h_last_next = h_last_clamp;
            endcase
        end
    end

    // Advance raster position on each input transfer
    assign in_fire = in_valid && in_ready;
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (col_cur >= w_last_reg)
            begin
                col_next = '0;
                row_next = (row_cur >= h_last_reg) ? '0 : row_cur + ROW_W'(1);
            end
            else
            begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= W_LAST_RST;
            h_last_reg <= H_LAST_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Line stores: word holds {two rows above, one row above} per column
    clbp_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({mid_s1, s1_pix_reg}),
        .re    (in_fire),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    // Forward the write-back when the next transfer reads the same column
    assign line_rd = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign top_s1  = line_rd[LINE_W-1:PIX_W];
    assign mid_s1  = line_rd[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            s2_res_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s1_res_reg   <= in_fire && (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
            s1_last_reg  <= in_fire && (row_cur == h_last_reg) && (col_cur == w_last_reg);
            s1_fwd_reg   <= in_fire && s1_valid_reg && (col_cur == s1_col_reg);
            s2_res_reg   <= s1_res_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Hold payload of the read stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg <= col_cur;
            s1_pix_reg <= pixel;
        end
        fwd_data_reg <= {mid_s1, s1_pix_reg};
    end

    // Shift the 3x3 window by one column per pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_s1;
            win_reg[1][2] <= mid_s1;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // Compare the eight samples against the centre
    always_comb
    begin
        code[0] = win_reg[1][2] > win_reg[1][1];
        code[1] = diag_bit(win_reg[0][2], win_reg[0][1], win_reg[1][2], win_reg[1][1]);
        code[2] = win_reg[0][1] > win_reg[1][1];
        code[3] = diag_bit(win_reg[0][0], win_reg[0][1], win_reg[1][0], win_reg[1][1]);
        code[4] = win_reg[1][0] > win_reg[1][1];
        code[5] = diag_bit(win_reg[2][0], win_reg[1][0], win_reg[2][1], win_reg[1][1]);
        code[6] = win_reg[2][1] > win_reg[1][1];
        code[7] = diag_bit(win_reg[2][2], win_reg[2][1], win_reg[1][2], win_reg[1][1]);
    end

    assign push_data.code = code;
    assign push_data.last = s2_last_reg;

    clbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_res_reg),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign lbp_code = fifo_data.code;
    assign last     = fifo_data.last;

    // Accept only while every result in flight has a FIFO slot
    assign reserved = (OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_res_reg)
                    + (OUT_CNT_W + 1)'(s2_res_reg);
    assign in_ready = reserved < (OUT_CNT_W + 1)'(OUT_DEPTH);

endmodule

`default_nettype wire

@@ rtl/core/clbp_checker.sv @@
// Port-level checker for the circular LBP stream block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "circular_lbp_3x3_stream_assert.svh"

module clbp_checker import clbp_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [PIX_W-1:0] lbp_code,
    input wire logic             last
);

    // A stalled result holds its value
    `CLBP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(lbp_code) && $stable(last), "stalled result changed")

    // A result that appears on an empty output stems from an earlier pixel transfer
    `CLBP_ASSERT(a_out_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 3), "result without matching input transfer")

    // Input backpressure only while results wait at the output
    `CLBP_ASSERT_NEVER(a_stall_backlog, !in_ready && !out_valid, "input stalled with empty output")

endmodule

bind circular_lbp_3x3_stream clbp_checker u_clbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lbp_code  (lbp_code),
    .last      (last)
);

`default_nettype wire

@@ dv/tb_circular_lbp_3x3_stream.sv @@
// Self-checking testbench for circular_lbp_3x3_stream: random stalls, frame geometry and codes.
`timescale 1ns / 1ps

import clbp_pkg::*;

class lbp_scoreboard;
    logic [PIX_W-1:0] line_prev  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] line_prev2 [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    lbp_result_t      pending [$];
    int               errors;

    function new();
        foreach (line_prev[i])
        begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        foreach (win[r, k])
            win[r][k] = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = FW_W'(FW_RESET);
        height_reg = FH_W'(FH_RESET);
        errors     = 0;
    endfunction

    function int unsigned width_in_use();
        if (width_reg < 3)
            return 3;
        if (width_reg > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return 32'(width_reg);
    endfunction

    function int unsigned height_in_use();
        if (height_reg < 3)
            return 3;
        if (height_reg > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return 32'(height_reg);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
            REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
            default: ;
        endcase
    endfunction

    // Interpolated diagonal sample strictly above the centre, exact in Q16
    function bit diag_above(logic [PIX_W-1:0] k, logic [PIX_W-1:0] a,
                            logic [PIX_W-1:0] b, logic [PIX_W-1:0] c);
        int unsigned sum;
        int unsigned centre_q16;
        sum = W_CORNER * int'(k) + W_SIDE * (int'(a) + int'(b)) + W_CENTRE * int'(c);
        centre_q16 = int'(c) << 16;
        return sum > centre_q16;
    endfunction

    // Advance the window for one accepted pixel and queue the code it yields
    function void note_pixel(logic [PIX_W-1:0] pix, logic fs);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] c;
        lbp_result_t      res;
        w = width_in_use();
        h = height_in_use();
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        top = line_prev2[col_pos];
        mid = line_prev[col_pos];
        line_prev2[col_pos] = mid;
        line_prev[col_pos]  = pix;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;

        if (row_pos >= 2 && col_pos >= 2)
        begin
            c = win[1][1];
            res.code[0] = win[1][2] > c;
            res.code[1] = diag_above(win[0][2], win[0][1], win[1][2], c);
            res.code[2] = win[0][1] > c;
            res.code[3] = diag_above(win[0][0], win[0][1], win[1][0], c);
            res.code[4] = win[1][0] > c;
            res.code[5] = diag_above(win[2][0], win[1][0], win[2][1], c);
            res.code[6] = win[2][1] > c;
            res.code[7] = diag_above(win[2][2], win[2][1], win[1][2], c);
            res.last    = (row_pos == h - 1) && (col_pos == w - 1);
            pending.insert(pending.size(), res);
        end

        // Wrap at the end of a row and of a frame
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endfunction

    function void check_result(logic [PIX_W-1:0] code, logic lst);
        lbp_result_t exp_res;
        if (pending.size() == 0)
        begin
            $error("unexpected result: lbp_code %02h last %0b", code, lst);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (code !== exp_res.code)
        begin
            $error("lbp_code mismatch: expected %02h, actual %02h", exp_res.code, code);
            errors++;
        end
        if (lst !== exp_res.last)
        begin
            $error("last mismatch: expected %0b, actual %0b", exp_res.last, lst);
            errors++;
        end
    endfunction
endclass

module tb_circular_lbp_3x3_stream;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 180;
    localparam int MAX_BURST     = 64;
    localparam int WIDE_ITEMS    = 32;
    localparam int TALL_ITEMS    = 48;
    localparam int HOLD_PHASE    = 0;
    localparam int PAUSE_PHASE   = 1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      lbp_code;
    logic                  last;

    lbp_scoreboard sb;
    int unsigned   send_gap_max;
    int unsigned   recv_gap_max;
    int unsigned   hold_cycles;
    bit            force_restart;
    int            cycle_count = 0;

    circular_lbp_3x3_stream uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lbp_code    (lbp_code),
        .last        (last)
    );

    always #6 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_circular_lbp_3x3_stream: done, errors");
            $finish;
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(lbp_code, last);
    end

    function automatic int unsigned draw_wait(input int unsigned max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    function automatic int unsigned pick_gap_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 18;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] gen_pixel(input int unsigned mode,
                                                   input logic [PIX_W-1:0] base);
        int v;
        case (mode)
            1:
            begin
                // Hover around a level so that ties and near-ties are common
                v = int'(base) + int'($urandom_range(0, 2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return v[PIX_W-1:0];
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return PIX_W'($urandom_range(0, 255));
                endcase
            end
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mark a frame start: forced after a width growth, usual at row 0 column 0,
    // and now and then in the middle of a frame
    function automatic logic next_frame_start();
        if (force_restart)
        begin
            force_restart = 1'b0;
            return 1'b1;
        end
        if (sb.col_pos == 0 && sb.row_pos == 0)
            return $urandom_range(0, 3) != 0;
        return $urandom_range(0, 59) == 0;
    endfunction

    task automatic wait_for_results();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        gap = draw_wait(send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(pix, fs);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Drain the block, then write the chosen registers
    task automatic configure(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input bit do_w, input bit do_h);
        int unsigned old_w;
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        old_w = sb.width_in_use();
        if ($urandom_range(0, 1) == 0)
        begin
            if (do_w)
                write_reg(REG_FRAME_WIDTH, w_data);
            if (do_h)
                write_reg(REG_FRAME_HEIGHT, h_data);
        end
        else
        begin
            if (do_h)
                write_reg(REG_FRAME_HEIGHT, h_data);
            if (do_w)
                write_reg(REG_FRAME_WIDTH, w_data);
        end
        cfg_valid <= 1'b0;
        // A wider row would read line store columns not filled in this frame
        if (sb.width_in_use() > old_w)
            force_restart = 1'b1;
    endtask

    // Output side: random stalls per result, plus a long hold-off on request
    initial
    begin
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = draw_wait(recv_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid && hold_cycles == 0);
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned area;
        int unsigned mode;
        int unsigned phase;
        int unsigned random_items;
        logic [PIX_W-1:0]      base;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        pixel         = '0;
        frame_start   = 1'b0;
        send_gap_max  = 3;
        recv_gap_max  = 3;
        hold_cycles   = 0;
        force_restart = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: two rows and a few pixels of a 320-wide frame
        for (int i = 0; i < 2 * FW_RESET + 8; i++)
            send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);

        // Minimal 3x3 frames; width 0 and height 1 clamp to 3, shrinking mid-frame
        configure(13'd0, 13'd1, 1'b1, 1'b1);
        send_gap_max = 18;
        recv_gap_max = 18;
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 8'h00 : 8'hFF, i == 0);
        // next frame follows the wrap, no frame_start
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 8'hFF : 8'h00, 1'b0);
        // flat frame: every diagonal sum ties the centre exactly
        for (int i = 0; i < 9; i++)
            send_pixel(8'h80, i == 0);

        // Widest row, clamped down from the register maximum; a short start of a row
        configure(13'h0FFF, 13'd3, 1'b1, 1'b1);
        send_gap_max = 3;
        recv_gap_max = 3;
        for (int i = 0; i < WIDE_ITEMS; i++)
            send_pixel(PIX_W'($urandom_range(0, 255)), next_frame_start());

        // Tallest frame with no idling; bit 12 of the width write is dropped,
        // and the column beyond the new width wraps at its next advance
        configure(13'h1003, 13'h1FFF, 1'b1, 1'b1);
        send_gap_max = 0;
        recv_gap_max = 0;
        for (int i = 0; i < TALL_ITEMS; i++)
            send_pixel(gen_pixel(2, 8'h00), next_frame_start());

        // Random geometry and content in short bursts
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 15))
                0:       w_data = CFG_DATA_W'($urandom_range(0, 2));
                1:       w_data = CFG_DATA_W'($urandom_range(13, 48));
                default: w_data = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            h_data = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                 : CFG_DATA_W'($urandom_range(3, 8));
            configure(w_data, h_data, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            send_gap_max = pick_gap_max();
            recv_gap_max = pick_gap_max();
            area = sb.width_in_use() * sb.height_in_use();
            n    = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
            if (n > MAX_BURST)
                n = MAX_BURST;
            if (phase == HOLD_PHASE)
            begin
                // Stall the output while input keeps flowing until the block backs up
                hold_cycles  = 300;
                send_gap_max = 0;
                n            = n + 60;
            end
            mode = $urandom_range(0, 2);
            base = PIX_W'($urandom_range(0, 255));
            for (int unsigned i = 0; i < n; i++)
            begin
                if (phase == PAUSE_PHASE && i == n / 2)
                begin
                    // Pause input mid-frame until all results are out
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait_for_results();
                end
                send_pixel(gen_pixel(mode, base), next_frame_start());
                random_items++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_circular_lbp_3x3_stream: done, clean");
        else
            $display("tb_circular_lbp_3x3_stream: done, errors");
        $finish;
    end

endmodule
